[hdl/rbd_pkg.sv]
`timescale 1ns / 1ps
package rbd_pkg;
  localparam int WINDOW_LEN_DEF  = 8;
  localparam int MAX_WORKERS_DEF = 64;

  localparam logic [2:0] CFG_TARGET   = 3'd0;
  localparam logic [2:0] CFG_HFLOOR   = 3'd1;
  localparam logic [2:0] CFG_CBASE    = 3'd2;
  localparam logic [2:0] CFG_CCAP     = 3'd3;
  localparam logic [2:0] CFG_DECAY    = 3'd4;
  localparam logic [2:0] CFG_SPERCENT = 3'd5;
  localparam logic [2:0] CFG_SFLOOR   = 3'd6;
  localparam logic [2:0] CFG_EMULT    = 3'd7;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_SYSTEMIC = 2'd1;
  localparam logic [1:0] CAUSE_EPOCH    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture word, update window, start sum
    logic sum_en;  // accumulate one window slot
    logic prep;    // health, thresholds
    logic decay;   // one halving step
    logic fin;     // pause decision, spawn, result
  } rbd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sum_last;
    logic decay_more;
  } rbd_sts_t;
endpackage

[hdl/rbd_ctrl.sv]
`timescale 1ns / 1ps
module rbd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rbd_pkg::rbd_cmd_t cmd,
  input  rbd_pkg::rbd_sts_t sts
);
  import rbd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_DECAY = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  // a new word is taken whenever the sequencer is idle
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        if (sts.sum_last) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DECAY;
      end
      S_DECAY: begin
        if (sts.decay_more) cmd.decay = 1'b1;
        else state_nxt = S_FIN;
      end
      S_FIN: begin
        // final step waits until the output register is free
        if (!ovalid_r || out_ready) begin
          cmd.fin    = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready)
    else $error("accepted word while busy");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid)
    else $error("result not presented");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
`endif
endmodule

[hdl/rbd_datapath.sv]
`timescale 1ns / 1ps
module rbd_datapath #(
  parameter int WINDOW_LEN  = rbd_pkg::WINDOW_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic [31:0] in_now_seconds,
  input  logic [6:0]  in_new_deaths,
  input  logic [6:0]  in_live_workers,
  input  logic [6:0]  in_launches_in_flight,
  input  logic        in_work_pending,
  input  logic [31:0] in_stall_deaths_total,
  input  logic [47:0] in_throughput_max,
  input  logic        in_abort_set,
  input  logic        in_stop_set,
  input  rbd_pkg::rbd_cmd_t cmd,
  output rbd_pkg::rbd_sts_t sts,
  output logic [6:0]  out_spawn_count,
  output logic        out_probe_launch,
  output logic        out_pausing,
  output logic [1:0]  out_pause_cause,
  output logic        out_abort_transfer,
  output logic [15:0] out_backlog_after
);
  import rbd_pkg::*;

  localparam int WW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SW = 8 + $clog2(WINDOW_LEN + 1);

  // configuration
  logic [6:0]  tgt_r, spct_r;
  logic [47:0] hfloor_r;
  logic [15:0] cbase_r, ccap_r, decay_r;
  logic [7:0]  sfloor_r, emult_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= 7'd4; hfloor_r <= 48'd2097152; cbase_r <= 16'd30; ccap_r <= 16'd600;
      decay_r <= 16'd60; spct_r <= 7'd25; sfloor_r <= 8'd3; emult_r <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET:   tgt_r    <= cfg_data[6:0];
        CFG_HFLOOR:   hfloor_r <= cfg_data;
        CFG_CBASE:    cbase_r  <= cfg_data[15:0];
        CFG_CCAP:     ccap_r   <= cfg_data[15:0];
        CFG_DECAY:    decay_r  <= cfg_data[15:0];
        CFG_SPERCENT: spct_r   <= cfg_data[6:0];
        CFG_SFLOOR:   sfloor_r <= cfg_data[7:0];
        CFG_EMULT:    emult_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // captured word
  logic [31:0] now_r;
  logic [6:0]  live_r, infl_r;
  logic        pend_r, abt_r, stp_r, hlt_in_r;

  // state
  logic [15:0] owed_r, plen_r, epoch_r;
  logic [31:0] last_r, hstart_r, dmark_r, resume_r;
  logic [7:0]  win_r [WINDOW_LEN];
  logic [WW-1:0] slot_r, sidx_r;
  logic [SW-1:0] sum_r;
  logic        healthy_r, sys_r;
  logic [14:0] sysmin_r;
  logic [14:0] ceil_r;

  // delta of the stall counter, clamped
  logic [31:0] dlt;
  logic [7:0]  dlt8;
  logic [16:0] owed_add;
  logic [13:0] pct_prod;
  logic [27:0] pct_mul;
  logic [14:0] pct_ceil;
  assign dlt      = (in_stall_deaths_total > last_r) ? in_stall_deaths_total - last_r : 32'd0;
  assign dlt8     = (dlt > 32'd255) ? 8'hFF : dlt[7:0];
  assign owed_add = {1'b0, owed_r} + {10'd0, in_new_deaths};
  assign pct_prod = tgt_r * spct_r;
  // divide by 100 rounding up: reciprocal multiply, exact over the product range
  assign pct_mul  = ({14'd0, pct_prod} + 28'd99) * 28'd5243;
  assign pct_ceil = {6'd0, pct_mul[27:19]};

  // decay step condition
  logic        dl_ok;
  assign dl_ok = (now_r >= dmark_r) && ((now_r - dmark_r) >= {16'd0, decay_r});
  assign sts.decay_more = healthy_r && (plen_r > cbase_r) && dl_ok;
  assign sts.sum_last   = (sidx_r == WW'(WINDOW_LEN - 1));

  // final decision
  logic        res_clear, clr_ep, in_p0, enter, in_pause;
  logic [15:0] epoch_eff;
  logic [32:0] rt;
  logic [16:0] pl2;
  logic [6:0]  slots, spawn;
  logic [16:0] ep_add;
  assign res_clear = (now_r >= resume_r) ||
    (healthy_r && hstart_r != 32'd0 && now_r >= hstart_r &&
     (now_r - hstart_r) >= {16'd0, decay_r});
  assign clr_ep    = (resume_r != 32'd0) && res_clear;
  assign epoch_eff = clr_ep ? 16'd0 : epoch_r;
  assign in_p0 = (resume_r != 32'd0) && !res_clear;
  assign enter = !in_p0 && owed_r != 16'd0 &&
                 (sys_r || {1'b0, epoch_eff} >= {2'b0, ceil_r});
  assign in_pause = in_p0 || enter;
  assign rt  = {1'b0, now_r} + {17'd0, plen_r};
  assign pl2 = {plen_r, 1'b0};
  assign slots = tgt_r - live_r;

  always_comb begin
    spawn = 7'd0;
    if (in_pause || abt_r || stp_r) spawn = 7'd0;
    else if (live_r == 7'd0) begin
      if (infl_r == 7'd0 && (owed_r != 16'd0 || pend_r)) spawn = 7'd1;
    end else if (owed_r != 16'd0 && tgt_r > live_r) begin
      spawn = ({9'd0, slots} > owed_r) ? owed_r[6:0] : slots;
    end
  end
  assign ep_add = (enter ? 17'd0 : {1'b0, epoch_eff}) + {10'd0, spawn};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= '0; plen_r <= '0; last_r <= '0; slot_r <= '0; hstart_r <= '0;
      dmark_r <= '0; resume_r <= '0; epoch_r <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) win_r[i] <= 8'd0;
    end else begin
      if (cmd.load) begin
        now_r <= in_now_seconds; live_r <= in_live_workers;
        infl_r <= in_launches_in_flight; pend_r <= in_work_pending;
        abt_r <= in_abort_set; stp_r <= in_stop_set;
        hlt_in_r <= (hfloor_r != 48'd0) && (in_throughput_max >= hfloor_r);
        owed_r <= owed_add[16] ? 16'hFFFF : owed_add[15:0];
        if (plen_r == 16'd0) plen_r <= cbase_r;
        last_r <= in_stall_deaths_total;
        win_r[slot_r] <= dlt8;
        slot_r <= (slot_r == WW'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;
        sidx_r <= '0;
        sum_r  <= '0;
        sysmin_r <= pct_ceil;
        ceil_r <= 15'(tgt_r * emult_r);
      end
      if (cmd.sum_en) begin
        sum_r  <= sum_r + SW'(win_r[sidx_r]);
        sidx_r <= sidx_r + 1'b1;
      end
      if (cmd.prep) begin
        sys_r <= {{(15 > SW ? 15 - SW : 0){1'b0}}, sum_r} >=
                 ((sysmin_r < {7'd0, sfloor_r}) ? {7'd0, sfloor_r} : sysmin_r);
        healthy_r <= hlt_in_r;
        if (hlt_in_r) begin
          if (hstart_r == 32'd0) begin
            hstart_r <= now_r; dmark_r <= now_r;
          end
        end else hstart_r <= 32'd0;
      end
      if (cmd.decay) begin
        plen_r  <= ((plen_r >> 1) < cbase_r) ? cbase_r : (plen_r >> 1);
        dmark_r <= dmark_r + {16'd0, decay_r};
      end
      if (cmd.fin) begin
        if (enter) begin
          resume_r <= rt[32] ? 32'hFFFF_FFFF : rt[31:0];
          dmark_r  <= now_r;
          hstart_r <= 32'd0;
          plen_r   <= (pl2 > {1'b0, ccap_r}) ? ccap_r : pl2[15:0];
        end else if (clr_ep) begin
          resume_r <= 32'd0;
        end
        epoch_r <= ep_add[16] ? 16'hFFFF : ep_add[15:0];
        owed_r <= owed_r - ((owed_r > {9'd0, spawn}) ? {9'd0, spawn} : owed_r);
        out_spawn_count    <= spawn;
        out_probe_launch   <= (spawn != 7'd0) && (live_r == 7'd0);
        out_pausing        <= in_pause;
        out_pause_cause    <= enter ? (sys_r ? CAUSE_SYSTEMIC : CAUSE_EPOCH) : CAUSE_NONE;
        out_abort_transfer <= (live_r == 7'd0) && (infl_r == 7'd0) && (spawn == 7'd0) &&
                              !in_pause && !abt_r && pend_r;
        out_backlog_after  <= owed_r - ((owed_r > {9'd0, spawn}) ? {9'd0, spawn} : owed_r);
      end
    end
  end

`ifndef SYNTH
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && enter) |=> out_pausing && out_pause_cause != CAUSE_NONE)
    else $error("pause entry without cause");
  a_nospawn: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && in_pause) |=> out_spawn_count == 7'd0)
    else $error("spawn during pause");
  a_plen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decay |=> plen_r >= cbase_r)
    else $error("pause length below base");
`endif
endmodule

[hdl/respawn_backoff_dispatcher.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake               Word
// in_      in   in_valid / in_ready     one supervisor tick
// out_     out  out_valid / out_ready   one dispatch result
// cfg_     in   cfg_we                  register write, cfg_index selects
//
// A result is registered after its tick passes the states SUM, PREP, DECAY (one
// pause-length halving per step) and FIN; the window sum walks one slot a cycle through one accumulator.
// The next tick is accepted at the edge after the result is registered.
// Synchronous active-low reset clears the sequencer, the window and pause state and restores register defaults.
// An unread result holds in the output register and stalls only the final step.
module respawn_backoff_dispatcher #(
  parameter int WINDOW_LEN  = rbd_pkg::WINDOW_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_now_seconds,
  input  logic [6:0]  in_new_deaths,
  input  logic [6:0]  in_live_workers,
  input  logic [6:0]  in_launches_in_flight,
  input  logic        in_work_pending,
  input  logic [31:0] in_stall_deaths_total,
  input  logic [47:0] in_throughput_max,
  input  logic        in_abort_set,
  input  logic        in_stop_set,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_spawn_count,
  output logic        out_probe_launch,
  output logic        out_pausing,
  output logic [1:0]  out_pause_cause,
  output logic        out_abort_transfer,
  output logic [15:0] out_backlog_after
);
  import rbd_pkg::*;

  rbd_cmd_t cmd;
  rbd_sts_t sts;

  rbd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  rbd_datapath #(.WINDOW_LEN(WINDOW_LEN)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_now_seconds(in_now_seconds),
    .in_new_deaths(in_new_deaths), .in_live_workers(in_live_workers),
    .in_launches_in_flight(in_launches_in_flight), .in_work_pending(in_work_pending),
    .in_stall_deaths_total(in_stall_deaths_total), .in_throughput_max(in_throughput_max),
    .in_abort_set(in_abort_set), .in_stop_set(in_stop_set), .cmd(cmd), .sts(sts),
    .out_spawn_count(out_spawn_count), .out_probe_launch(out_probe_launch),
    .out_pausing(out_pausing), .out_pause_cause(out_pause_cause),
    .out_abort_transfer(out_abort_transfer), .out_backlog_after(out_backlog_after)
  );
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import rbd_pkg::*;

  localparam int WIN = 8;

  // tick word as queued for the driver
  typedef struct packed {
    logic [31:0] now_s;
    logic [6:0]  deaths;
    logic [6:0]  live;
    logic [6:0]  inflight;
    logic        pending;
    logic [31:0] stall_total;
    logic [47:0] tput;
    logic        abort_f;
    logic        stop_f;
  } tick_t;

  // dispatch result word
  typedef struct packed {
    logic [6:0]  spawn;
    logic        probe;
    logic        pausing;
    logic [1:0]  cause;
    logic        abort_t;
    logic [15:0] backlog;
  } disp_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = CFG_TARGET;
  logic [47:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  tick_t cur = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [6:0]  o_spawn;
  logic        o_probe, o_pausing, o_abort;
  logic [1:0]  o_cause;
  logic [15:0] o_backlog;
  disp_t got;

  assign got = {o_spawn, o_probe, o_pausing, o_cause, o_abort, o_backlog};

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  respawn_backoff_dispatcher DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_now_seconds(cur.now_s), .in_new_deaths(cur.deaths),
    .in_live_workers(cur.live), .in_launches_in_flight(cur.inflight),
    .in_work_pending(cur.pending), .in_stall_deaths_total(cur.stall_total),
    .in_throughput_max(cur.tput), .in_abort_set(cur.abort_f), .in_stop_set(cur.stop_f),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_spawn_count(o_spawn), .out_probe_launch(o_probe),
    .out_pausing(o_pausing), .out_pause_cause(o_cause),
    .out_abort_transfer(o_abort), .out_backlog_after(o_backlog)
  );

  // predictor configuration and state
  logic [6:0]  c_target;
  logic [47:0] c_hfloor;
  logic [15:0] c_base, c_cap, c_decay;
  logic [6:0]  c_pct;
  logic [7:0]  c_sfloor, c_emult;
  logic [15:0] owed, plen, epoch;
  logic [31:0] last_stall, hstart, dmark, resume;
  logic [7:0]  win [WIN];
  logic [2:0]  slot;

  tick_t pending_ticks[$];
  disp_t expected_disp[$];
  int mismatches = 0;
  int unexpected = 0;
  int accepted = 0;
  int checked = 0;
  int gap_in = 0;
  int gap_out = 0;
  int cfg_writes = 0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit span_done(logic [31:0] n, logic [31:0] t, logic [15:0] span);
    if (n < t) return 0;
    return (n - t) >= {16'd0, span};
  endfunction

  task automatic reset_model();
    c_target = 4; c_hfloor = 48'd2097152; c_base = 30; c_cap = 600; c_decay = 60;
    c_pct = 25; c_sfloor = 3; c_emult = 4;
    owed = 0; plen = 0; epoch = 0; last_stall = 0; hstart = 0; dmark = 0;
    resume = 0; slot = 0;
    for (int i = 0; i < WIN; i++) win[i] = 0;
  endtask

  task automatic model_cfg(logic [2:0] idx, logic [47:0] v);
    case (idx)
      CFG_TARGET:   c_target = v[6:0];
      CFG_HFLOOR:   c_hfloor = v;
      CFG_CBASE:    c_base = v[15:0];
      CFG_CCAP:     c_cap = v[15:0];
      CFG_DECAY:    c_decay = v[15:0];
      CFG_SPERCENT: c_pct = v[6:0];
      CFG_SFLOOR:   c_sfloor = v[7:0];
      CFG_EMULT:    c_emult = v[7:0];
      default: ;
    endcase
  endtask

  // compute one dispatch result and advance the predictor state
  function automatic disp_t predict_dispatch(tick_t tk);
    disp_t r;
    logic [16:0] owed_w;
    logic [31:0] delta, sum;
    logic [31:0] sys_min, ceiling;
    logic [32:0] tsum;
    logic [16:0] twice;
    logic [16:0] ep_w;
    logic [6:0] spawn, slots;
    logic [1:0] cause;
    bit systemic, healthy, paused;
    cause = CAUSE_NONE;
    paused = 0;
    owed_w = owed + tk.deaths;
    owed = (owed_w > 17'hFFFF) ? 16'hFFFF : owed_w[15:0];
    if (plen == 0) plen = c_base;
    delta = (tk.stall_total > last_stall) ? tk.stall_total - last_stall : 0;
    if (delta > 255) delta = 255;
    last_stall = tk.stall_total;
    win[slot] = delta[7:0];
    slot = slot + 1;
    sum = 0;
    for (int i = 0; i < WIN; i++) sum += win[i];
    sys_min = (c_target * c_pct + 99) / 100;
    if (sys_min < c_sfloor) sys_min = c_sfloor;
    systemic = sum >= sys_min;
    healthy = (c_hfloor != 0) && (tk.tput >= c_hfloor);
    if (healthy) begin
      if (hstart == 0) begin
        hstart = tk.now_s;
        dmark = tk.now_s;
      end
      while (plen > c_base && span_done(tk.now_s, dmark, c_decay)) begin
        plen = plen / 2;
        if (plen < c_base) plen = c_base;
        dmark = dmark + c_decay;
      end
    end else begin
      hstart = 0;
    end
    if (resume != 0) begin
      if (tk.now_s >= resume) begin
        resume = 0; epoch = 0;
      end else if (healthy && hstart != 0 && span_done(tk.now_s, hstart, c_decay)) begin
        resume = 0; epoch = 0;
      end else begin
        paused = 1;
      end
    end
    ceiling = c_target * c_emult;
    if (!paused && owed > 0 && (systemic || epoch >= ceiling)) begin
      tsum = tk.now_s + plen;
      resume = tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
      dmark = tk.now_s;
      hstart = 0;
      epoch = 0;
      paused = 1;
      cause = systemic ? CAUSE_SYSTEMIC : CAUSE_EPOCH;
      twice = {plen, 1'b0};
      plen = (twice > c_cap) ? c_cap : twice[15:0];
    end
    spawn = 0;
    if (paused || tk.abort_f || tk.stop_f) begin
      spawn = 0;
    end else if (tk.live == 0) begin
      if (tk.inflight == 0 && (owed > 0 || tk.pending)) spawn = 1;
    end else if (owed > 0 && c_target > tk.live) begin
      slots = c_target - tk.live;
      spawn = (owed < slots) ? owed[6:0] : slots;
    end
    ep_w = epoch + spawn;
    epoch = (ep_w > 17'hFFFF) ? 16'hFFFF : ep_w[15:0];
    owed = (spawn < owed) ? owed - spawn : 0;
    r.spawn = spawn;
    r.probe = (spawn > 0) && (tk.live == 0);
    r.pausing = paused;
    r.cause = cause;
    r.abort_t = (tk.live == 0) && (tk.inflight + spawn == 0) && !paused && !tk.abort_f
                && tk.pending;
    r.backlog = owed;
    return r;
  endfunction

  // driver: present queued ticks with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_disp.push_back(predict_dispatch(cur));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_in > 0) begin
          gap_in--;
          in_valid <= 0;
        end else if (pending_ticks.size() > 0) begin
          cur <= pending_ticks.pop_front();
          in_valid <= 1;
          gap_in = rand_gap();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    disp_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_disp.size() == 0) begin
          unexpected++;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", got);
        end else begin
          e = expected_disp.pop_front();
          checked++;
          if (e !== got) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch #%0d: spawn %0d/%0d probe %b/%b pause %b/%b ",
                        "cause %0d/%0d abort %b/%b backlog %0d/%0d"},
                       checked, e.spawn, got.spawn, e.probe, got.probe, e.pausing,
                       got.pausing, e.cause, got.cause, e.abort_t, got.abort_t,
                       e.backlog, got.backlog);
          end
        end
      end
      if (gap_out > 0) begin
        gap_out--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        gap_out = rand_gap();
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    model_cfg(idx, v);
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pending_ticks.size() > 0 || in_valid || expected_disp.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // random register set inside the legal ranges, mostly small values
  task automatic rand_config();
    int r;
    write_reg(CFG_TARGET, 48'($urandom_range(1, 64)));
    r = $urandom_range(0, 9);
    if (r < 2) write_reg(CFG_HFLOOR, 48'd0);
    else if (r < 8) write_reg(CFG_HFLOOR, 48'($urandom_range(1000000, 6000000)));
    else write_reg(CFG_HFLOOR, 48'({$urandom, $urandom}));
    write_reg(CFG_CBASE, 48'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 60)
                                                         : $urandom_range(1, 65535)));
    write_reg(CFG_CCAP, 48'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 1000)
                                                        : $urandom_range(1, 65535)));
    write_reg(CFG_DECAY, 48'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 90)
                                                         : $urandom_range(1, 65535)));
    write_reg(CFG_SPERCENT, 48'($urandom_range(0, 100)));
    write_reg(CFG_SFLOOR, 48'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 12)
                                                          : $urandom_range(1, 255)));
    write_reg(CFG_EMULT, 48'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 6)
                                                         : $urandom_range(1, 255)));
  endtask

  // clock time advances slowly so pauses and decay actually expire
  logic [31:0] clock_s;
  logic [31:0] stall_run;

  function automatic tick_t rand_tick();
    tick_t t;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) clock_s = $urandom;
    else if (r < 8) clock_s = clock_s - $urandom_range(1, 50);
    else clock_s = clock_s + $urandom_range(0, r < 80 ? 5 : 120);
    t.now_s = clock_s;
    t.deaths = ($urandom_range(0, 9) < 6) ? 7'($urandom_range(0, 3)) : 7'($urandom_range(0, 64));
    t.live = ($urandom_range(0, 4) == 0) ? 7'd0 : 7'($urandom_range(0, 64));
    t.inflight = ($urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom_range(0, 64));
    t.pending = 1'($urandom);
    r = $urandom_range(0, 99);
    if (r < 60) stall_run = stall_run;
    else if (r < 85) stall_run = stall_run + $urandom_range(1, 3);
    else if (r < 92) stall_run = stall_run + $urandom_range(200, 1000);
    else if (r < 96) stall_run = stall_run - $urandom_range(1, 20);
    else stall_run = $urandom;
    t.stall_total = stall_run;
    r = $urandom_range(0, 9);
    t.tput = (r < 5) ? 48'($urandom_range(3000000, 9000000)) :
             (r < 8) ? 48'($urandom_range(0, 2000000)) : 48'({$urandom, $urandom});
    t.abort_f = ($urandom_range(0, 19) == 0);
    t.stop_f = ($urandom_range(0, 19) == 0);
    return t;
  endfunction

  // run limit
  initial begin
    #2000000;
    $display("Run stopped at the time limit: %0d of %0d results checked", checked, accepted);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    tick_t t;
    reset_model();
    clock_s = 100;
    stall_run = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes and special cases at reset settings
    t = '0; pending_ticks.push_back(t);                       // healthy-less tick at time zero
    t.pending = 1; pending_ticks.push_back(t);                // empty pool with work, probe
    t = '0; t.deaths = 64; t.live = 2; t.tput = 48'd5000000; pending_ticks.push_back(t);
    t.now_s = 0; t.live = 64; pending_ticks.push_back(t);     // pool above target
    t = '0; t.now_s = 10; t.stall_total = 32'hFFFFFFFF; t.deaths = 5; t.live = 1;
    pending_ticks.push_back(t);                               // large stall delta -> pause
    t.now_s = 20; t.stall_total = 5; pending_ticks.push_back(t); // counter going back
    t.now_s = 5; pending_ticks.push_back(t);                  // time going back
    t = '0; t.now_s = 32'hFFFFFFF0; t.deaths = 64; t.live = 1; t.stall_total = 300;
    pending_ticks.push_back(t);                               // resume time overflow
    t = '0; t.now_s = 32'hFFFFFFFF; t.tput = 48'hFFFF_FFFF_FFFF; t.live = 64;
    t.inflight = 64; t.deaths = 64; t.pending = 1;
    pending_ticks.push_back(t);                               // time and throughput at top, counts at 64, work pending
    drain();

    // random ticks at reset settings, then under random register sets
    for (int n = 0; n < 250; n++) pending_ticks.push_back(rand_tick());
    drain();
    for (int p = 0; p < 7; p++) begin
      rand_config();
      for (int n = 0; n < 200; n++) pending_ticks.push_back(rand_tick());
      drain();
    end

    $display("Run covered: %0d ticks accepted, %0d results checked, %0d register writes",
             accepted, checked, cfg_writes);
    $display("Directed corner ticks plus random ticks under eight register sets, stalls on both sides");
    if (mismatches == 0 && expected_disp.size() == 0 && checked == accepted)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
